@@ sv/apif_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apif_pkg
// Shared widths, register indexes and types of the all-pole IIR filter.
// ---------------------------------------------------------------------------
package apif_pkg;

  localparam int MAX_ORDER     = 4;   // cells in the chain, 1 to 8
  localparam int SAMPLE_BITS   = 24;  // Q1.23 sample, 16 to 32
  localparam int COEF_BITS     = 24;  // Q4.20 coefficient
  localparam int COEF_FRAC     = 20;
  localparam int NUM_COEF_REGS = 4;   // cells past this carry a zero weight

  localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS      = PROD_BITS + $clog2(MAX_ORDER + 1) + 1;
  localparam int RND_BITS      = ACC_BITS - COEF_FRAC;

  localparam int TDATA_BITS    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = COEF_BITS;
  localparam int ORDER_BITS    = 3;
  // wide enough to compare the order register against MAX_ORDER up to 8
  localparam int ORD_CMP_BITS  = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_FILTER_ORDER = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_ONE     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_TWO     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_THREE   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_FOUR    = 3'd4;

  // per-cell control
  typedef struct packed {
    logic shift;    // take the neighbour's history word
    logic tap_en;   // tap lies within the filter order
    logic coef_we;  // write this cell's coefficient
  } apif_cell_ctl_t;

  // one result beat
  typedef struct packed {
    logic                          clipped;
    logic signed [SAMPLE_BITS-1:0] sample;
  } apif_res_t;

endpackage
`default_nettype wire

@@ sv/apif_tap_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apif_tap_cell
// One pole tap: holds one past output and its weight, hands the past output
// on to the next cell and gives the weighted product.
// ---------------------------------------------------------------------------
module apif_tap_cell
  import apif_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire apif_cell_ctl_t                ctl,
  input  wire logic signed [COEF_BITS-1:0]   coef_wdata,
  input  wire logic signed [SAMPLE_BITS-1:0] hist_in,
  output logic signed [SAMPLE_BITS-1:0]      hist_out,
  output logic signed [PROD_BITS-1:0]        prod
);

  logic signed [SAMPLE_BITS-1:0] hist_r;
  logic signed [SAMPLE_BITS-1:0] hist_nxt;
  logic signed [COEF_BITS-1:0]   coef_r;
  logic signed [COEF_BITS-1:0]   coef_nxt;

  always_comb begin
    hist_nxt = ctl.shift   ? hist_in    : hist_r;
    coef_nxt = ctl.coef_we ? coef_wdata : coef_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
      coef_r <= '0;
    end else begin
      hist_r <= hist_nxt;
      coef_r <= coef_nxt;
    end
  end

  assign hist_out = hist_r;
  assign prod     = ctl.tap_en ? PROD_BITS'(hist_r * coef_r) : '0;

endmodule
`default_nettype wire

@@ sv/apif_out_skid.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// apif_out_skid
// Two-entry result buffer: output register plus skid register, so the
// input side can still take one beat while a result waits.
// ---------------------------------------------------------------------------
module apif_out_skid
  import apif_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire apif_res_t push_data,
  output logic           push_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output apif_res_t      out_data
);

  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      skid_valid_r;
  logic      skid_valid_nxt;
  apif_res_t out_data_r;
  apif_res_t out_data_nxt;
  apif_res_t skid_data_r;
  apif_res_t skid_data_nxt;
  logic      pop;

  assign pop = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = push_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with output register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("beat pushed into a full buffer");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && skid_valid_r && pop |=> out_data_r == $past(skid_data_r))
    else $error("skid entry lost on drain");
`endif

endmodule
`default_nettype wire

@@ sv/all_pole_iir_filter_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// all_pole_iir_filter_unit
// All-pole IIR filter of order 1 to 4: y(n) = x(n) - sum b_k * y(n-k),
// built as a chain of tap cells with a two-entry result buffer.
// ---------------------------------------------------------------------------
//
//  channel  direction  beat contents
//  in_      slave      tdata[23:0] sample_in (Q1.23)
//  out_     master     tdata[23:0] sample_out (Q1.23), tuser[0] clipped
//  cfg_     slave      index 0 filter_order, 1..4 coef_one..coef_four (Q4.20)
//
//  One beat per cycle sustained while out_ is not stalled; a result is
//  registered when its input beat is taken. The feedback path (cell
//  products, the sum, rounding and saturation into cell 0) is combinational.
//  Synchronous reset clears the history, sets the order to 1, weights to 0.
//  A stall on out_ fills the skid entry; in_tready drops only when both
//  result entries are full. cfg_ready is always high.
//
module all_pole_iir_filter_unit
  import apif_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // input samples
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [TDATA_BITS-1:0]    in_tdata,   // [23:0] sample_in
  // filtered samples
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [TDATA_BITS-1:0]         out_tdata,  // [23:0] sample_out
  output logic [0:0]                    out_tuser,  // [0] clipped
  // register writes
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic                          push;
  logic                          cfg_we;
  logic [ORDER_BITS-1:0]         order_r;
  logic [ORDER_BITS-1:0]         order_nxt;
  logic [ORD_CMP_BITS-1:0]       order_eff;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [ACC_BITS-1:0]    acc_rnd;
  logic signed [RND_BITS-1:0]    y_wide;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          clip;
  apif_res_t                     res;
  apif_res_t                     out_res;
  apif_cell_ctl_t                ctl   [MAX_ORDER];
  logic signed [SAMPLE_BITS-1:0] hist  [MAX_ORDER];
  logic signed [SAMPLE_BITS-1:0] hin   [MAX_ORDER];
  logic signed [PROD_BITS-1:0]   prod  [MAX_ORDER];

  localparam logic signed [RND_BITS-1:0] Y_MAX =
    {{(RND_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [RND_BITS-1:0] Y_MIN =
    {{(RND_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] RND_HALF =
    ACC_BITS'(1) <<< (COEF_FRAC - 1);

  assign push      = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign x         = in_tdata[SAMPLE_BITS-1:0];

  // order register
  always_comb begin
    order_nxt = order_r;
    if (cfg_we && cfg_index == REG_FILTER_ORDER) begin
      order_nxt = cfg_data[ORDER_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_BITS'(1);
    end else begin
      order_r <= order_nxt;
    end
  end

  // zero acts as one, anything past the chain length as the full chain
  always_comb begin
    order_eff = ORD_CMP_BITS'(order_r);
    if (order_r == '0) begin
      order_eff = ORD_CMP_BITS'(1);
    end else if (ORD_CMP_BITS'(order_r) > ORD_CMP_BITS'(MAX_ORDER)) begin
      order_eff = ORD_CMP_BITS'(MAX_ORDER);
    end
  end

  // tap chain
  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign hin[k] = y_sat;
    end else begin : g_link
      assign hin[k] = hist[k-1];
    end

    if (k < NUM_COEF_REGS) begin : g_wr
      assign ctl[k].coef_we = cfg_we &&
        (cfg_index == REG_COEF_ONE + CFG_IDX_BITS'(k));
    end else begin : g_nowr
      assign ctl[k].coef_we = 1'b0;   // no register: weight stays zero
    end

    assign ctl[k].shift  = push;
    assign ctl[k].tap_en = ORD_CMP_BITS'(k) < order_eff;

    apif_tap_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl[k]),
      .coef_wdata (cfg_data[COEF_BITS-1:0]),
      .hist_in    (hin[k]),
      .hist_out   (hist[k]),
      .prod       (prod[k])
    );
  end

  // x in Q.20 minus the tap products, round half up, saturate
  always_comb begin
    acc = ACC_BITS'(x) <<< COEF_FRAC;
    for (int k = 0; k < MAX_ORDER; k++) begin
      acc = acc - ACC_BITS'(prod[k]);
    end
    acc_rnd = acc + RND_HALF;
    y_wide  = acc_rnd[ACC_BITS-1:COEF_FRAC];
    clip    = 1'b0;
    y_sat   = y_wide[SAMPLE_BITS-1:0];
    if (y_wide > Y_MAX) begin
      y_sat = Y_MAX[SAMPLE_BITS-1:0];
      clip  = 1'b1;
    end else if (y_wide < Y_MIN) begin
      y_sat = Y_MIN[SAMPLE_BITS-1:0];
      clip  = 1'b1;
    end
  end

  assign res.sample  = y_sat;
  assign res.clipped = clip;

  apif_out_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata    = TDATA_BITS'(unsigned'(out_res.sample));
  assign out_tuser[0] = out_res.clipped;

`ifndef ASSERT_OFF
  a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      (out_res.sample == Y_MAX[SAMPLE_BITS-1:0]) ||
      (out_res.sample == Y_MIN[SAMPLE_BITS-1:0]))
    else $error("clipped flag on a sample off the rail");

  a_history_takes_result: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && push |=> hist[0] == $past(y_sat))
    else $error("history head differs from the result just produced");

  a_order_write: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cfg_we && cfg_index == REG_FILTER_ORDER |=>
      order_r == $past(cfg_data[ORDER_BITS-1:0]))
    else $error("filter order write not taken");
`endif

endmodule
`default_nettype wire

@@ bench/apif_filter_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// apif_filter_checker
// Watches the sample, result and register channels of the all-pole filter,
// runs its own copy of the recursion and compares every result beat.
// ---------------------------------------------------------------------------
module apif_filter_checker
  import apif_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  input  wire logic                     in_tready,
  input  wire logic [TDATA_BITS-1:0]    in_tdata,
  input  wire logic                     out_tvalid,
  input  wire logic                     out_tready,
  input  wire logic [TDATA_BITS-1:0]    out_tdata,
  input  wire logic [0:0]               out_tuser,
  input  wire logic                     cfg_valid,
  input  wire logic                     cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                            results_seen,
  output int                            fail_count,
  output int                            open_count
);

  logic [ORDER_BITS-1:0]         order_reg = ORDER_BITS'(1);
  logic signed [COEF_BITS-1:0]   coef_w [NUM_COEF_REGS];
  logic signed [SAMPLE_BITS-1:0] y_hist [MAX_ORDER];
  apif_res_t                     pending_outputs [$];

  int fail_tally = 0;
  int seen_q     = 0;
  int fail_q     = 0;
  int open_q     = 0;

  assign results_seen = seen_q;
  assign fail_count   = fail_q;
  assign open_count   = open_q;

  initial begin
    for (int k = 0; k < NUM_COEF_REGS; k++) coef_w[k] = '0;
    for (int k = 0; k < MAX_ORDER; k++) y_hist[k] = '0;
  end

  // next output from x and the current history and weights
  function automatic apif_res_t filter_next(input logic signed [SAMPLE_BITS-1:0] x);
    longint    acc;
    longint    y;
    longint    top_val;
    longint    bot_val;
    int        taps;
    apif_res_t r;
    top_val = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    bot_val = -top_val - 1;
    if (order_reg == 0)
      taps = 1;
    else if (order_reg > MAX_ORDER)
      taps = MAX_ORDER;
    else
      taps = int'(order_reg);
    acc = longint'(x) <<< COEF_FRAC;
    for (int k = 0; k < taps; k++) begin
      if (k < NUM_COEF_REGS)
        acc -= longint'(coef_w[k]) * longint'(y_hist[k]);
    end
    // round half up, then floor
    y = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
    r.clipped = 1'b0;
    if (y > top_val) begin
      y = top_val;
      r.clipped = 1'b1;
    end else if (y < bot_val) begin
      y = bot_val;
      r.clipped = 1'b1;
    end
    r.sample = SAMPLE_BITS'(y);
    return r;
  endfunction

  always @(posedge clk) begin
    apif_res_t want;
    apif_res_t got;
    if (!rst_n) begin
      order_reg = ORDER_BITS'(1);
      for (int k = 0; k < NUM_COEF_REGS; k++) coef_w[k] = '0;
      for (int k = 0; k < MAX_ORDER; k++) y_hist[k] = '0;
      pending_outputs.delete();
    end else begin
      // push before pop: a beat and its own result never share an edge
      if (in_tvalid && in_tready) begin
        want = filter_next(in_tdata[SAMPLE_BITS-1:0]);
        pending_outputs.push_back(want);
        for (int k = MAX_ORDER - 1; k > 0; k--) y_hist[k] = y_hist[k-1];
        y_hist[0] = want.sample;
      end
      if (out_tvalid && out_tready) begin
        seen_q    <= seen_q + 1;
        got.sample  = out_tdata[SAMPLE_BITS-1:0];
        got.clipped = out_tuser[0];
        if (pending_outputs.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got sample %0d clipped %0b",
                   $time, $signed(got.sample), got.clipped);
          fail_tally++;
        end else begin
          want = pending_outputs.pop_front();
          if (got.sample !== want.sample) begin
            $display("%0t: sample_out expected %0d, got %0d",
                     $time, $signed(want.sample), $signed(got.sample));
            fail_tally++;
          end
          if (got.clipped !== want.clipped) begin
            $display("%0t: clipped expected %0b, got %0b",
                     $time, want.clipped, got.clipped);
            fail_tally++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FILTER_ORDER: order_reg = cfg_data[ORDER_BITS-1:0];
          REG_COEF_ONE:     coef_w[0] = cfg_data;
          REG_COEF_TWO:     coef_w[1] = cfg_data;
          REG_COEF_THREE:   coef_w[2] = cfg_data;
          REG_COEF_FOUR:    coef_w[3] = cfg_data;
          default: ;  // unmapped index, dropped
        endcase
      end
    end
    fail_q <= fail_tally;
    open_q <= pending_outputs.size();
  end

endmodule

@@ bench/tb_all_pole_iir_filter_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_all_pole_iir_filter_unit
// Drives samples and register writes into the all-pole filter, stalls the
// result side at random, and leaves prediction and comparison to the
// checker instance beside the block.
// ---------------------------------------------------------------------------
module tb_all_pole_iir_filter_unit
  import apif_pkg::*;
();

  // sample and weight extremes
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0]   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic [COEF_BITS-1:0]   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic [COEF_BITS-1:0]   COEF_ONE   = COEF_BITS'(1) << COEF_FRAC;  // +1.0
  localparam logic [COEF_BITS-1:0]   COEF_HALF  = COEF_BITS'(1) << (COEF_FRAC - 1);
  localparam int                     RANDOM_ITEMS = 1400;
  localparam int                     LONG_HOLD    = 300;  // receiver hold-off, cycles

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [TDATA_BITS-1:0]    in_tdata;   // [23:0] sample_in
  logic                     out_tvalid;
  logic                     out_tready;
  logic [TDATA_BITS-1:0]    out_tdata;  // [23:0] sample_out
  logic [0:0]               out_tuser;  // [0] clipped
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int chk_results;
  int chk_fails;
  int chk_open;

  int n_sent   = 0;
  bit in_fast  = 1'b0;   // sender offers back to back
  bit out_fast = 1'b0;   // receiver takes back to back
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off

  all_pole_iir_filter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  apif_filter_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .results_seen (chk_results),
    .fail_count   (chk_fails),
    .open_count   (chk_open)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop, well past the slowest legal run
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers. Each task returns just after a rising edge, so the
  // next nonblocking drive lands in a step of its own.
  // ------------------------------------------------------------------------

  // offer one sample; valid stays high into the next call when it has no gap
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = in_fast ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_BITS'(s);
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  // drop valid and wait for every result to come back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (chk_results != n_sent) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register set, written only once the filter has drained
  task automatic load_setting(input logic [ORDER_BITS-1:0] order,
                              input logic [COEF_BITS-1:0]  b1,
                              input logic [COEF_BITS-1:0]  b2,
                              input logic [COEF_BITS-1:0]  b3,
                              input logic [COEF_BITS-1:0]  b4,
                              input bit                    junk);
    settle();
    // a write to an unmapped index must leave everything alone
    if (junk)
      write_reg(CFG_IDX_BITS'($urandom_range(REG_COEF_FOUR + 1, (1 << CFG_IDX_BITS) - 1)),
                CFG_DATA_BITS'($urandom));
    write_reg(REG_FILTER_ORDER, CFG_DATA_BITS'(order));
    write_reg(REG_COEF_ONE,     b1);
    write_reg(REG_COEF_TWO,     b2);
    write_reg(REG_COEF_THREE,   b3);
    write_reg(REG_COEF_FOUR,    b4);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return SAMPLE_BITS'($urandom_range(0, 8191) - 4096);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // kind 0: small stable weights, 1: any value, 2: extremes and unity
  function automatic logic [COEF_BITS-1:0] pick_coef(input int kind);
    case (kind)
      0: return COEF_BITS'($urandom_range(0, 'h80000) - 'h40000);
      1: return COEF_BITS'($urandom);
      default:
        case ($urandom_range(0, 4))
          0:       return COEF_MAX;
          1:       return COEF_MIN;
          2:       return COEF_ONE;
          3:       return -COEF_ONE;
          default: return '0;
        endcase
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Result side: random hold-offs per beat, one long hold on request
  // ------------------------------------------------------------------------
  initial begin
    int w;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        w = LONG_HOLD;
      end else begin
        w = out_fast ? 0 : $urandom_range(0, 15);
      end
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin
    int                    kind;
    int                    len;
    int                    phase;
    logic [ORDER_BITS-1:0] order;

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_FILTER_ORDER;
    cfg_data  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset weights are zero: output equals input, history still moves
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_BITS'(1));
    send_sample('1);
    send_sample({(SAMPLE_BITS/2){2'b01}});
    send_sample({(SAMPLE_BITS/2){2'b10}});

    // b1 = -1.0: running sum, clips high then low
    load_setting(ORDER_BITS'(1), -COEF_ONE, '0, '0, '0, 1'b0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);

    // b1 = 0.5: exact halves, both signs, round toward plus infinity
    load_setting(ORDER_BITS'(1), COEF_HALF, '0, '0, '0, 1'b0);
    send_sample(SAMPLE_BITS'(1));
    send_sample('0);
    send_sample('1);
    send_sample('0);

    // full order with extreme weights, plus a dropped write
    load_setting(ORDER_BITS'(MAX_ORDER), COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, 1'b1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(pick_sample());

    // order above range clamps to four, order zero acts as one
    load_setting('1, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, 1'b0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    load_setting('0, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, 1'b0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_BITS'(1));

    // random phases: fresh register set, then a run of samples
    phase = 0;
    while (n_sent < RANDOM_ITEMS + 25) begin
      kind  = $urandom_range(0, 2);
      order = ORDER_BITS'($urandom_range(0, 7));
      // mostly well-behaved weights so the recursion is not pinned at the rails
      if ($urandom_range(0, 1) == 0) kind = 0;
      load_setting(order, pick_coef(kind), pick_coef(kind), pick_coef(kind),
                   pick_coef(kind), $urandom_range(0, 3) == 0);
      in_fast  = ($urandom_range(0, 3) == 0);
      out_fast = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        // back-pressure: sender keeps offering while the receiver sits out
        in_fast  = 1'b1;
        hold_req = 1'b1;
      end
      len = $urandom_range(20, 120);
      repeat (len) send_sample(pick_sample());
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (chk_fails == 0 && chk_open == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
